/* src/lba_pkg.sv */
// Package for the largest-block allocator: payload words, table entries,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package lba_pkg;

  localparam int CELL_W = 17;
  localparam int SUM_W  = 18;
  localparam int TGT_W  = 13;
  localparam int REQ_W  = 13;

  typedef logic [CELL_W-1:0] cell_t;

  // Input word: one request.
  typedef struct packed {
    logic              action;
    logic [CELL_W-1:0] alloc_size;
    logic [TGT_W-1:0]  target_request;
  } lba_in_t;

  // Output word: answer to one allocate request.
  typedef struct packed {
    logic [REQ_W-1:0]  request_number;
    logic [CELL_W-1:0] start_address;
    logic              failed;
  } lba_out_t;

  // Free-block table entry.
  typedef struct packed {
    logic  valid;
    cell_t start;
    cell_t size;
  } lba_blk_t;

  // Grant table entry.
  typedef struct packed {
    logic  granted;
    cell_t start;
    cell_t size;
  } lba_grant_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRANT_CHK,
    ST_SCAN,
    ST_ALLOC_UPD,
    ST_RESULT,
    ST_FREE_UPD1,
    ST_FREE_UPD2
  } lba_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan_step;
    logic alloc_upd;
    logic free_upd1;
    logic free_upd2;
    logic emit;
  } lba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic new_free;
    logic op_free;
    logic target_ok;
    logic scan_done;
    logic both;
    logic out_free;
  } lba_sts_t;

endpackage

/* src/lba_ctrl.sv */
// Controller state machine for the largest-block allocator.
// Depends on lba_pkg.
`timescale 1ns / 1ps

module lba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lba_pkg::lba_sts_t sts,
  output lba_pkg::lba_cmd_t cmd
);
  import lba_pkg::*;

  lba_state_t state_r;
  lba_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (!sts.full) begin
            state_nxt = (sts.new_free == ACT_FREE) ? ST_GRANT_CHK : ST_SCAN;
          end
        end
      end
      ST_GRANT_CHK: begin
        state_nxt = sts.target_ok ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.op_free ? ST_FREE_UPD1 : ST_ALLOC_UPD;
        end
      end
      ST_ALLOC_UPD: begin
        cmd.alloc_upd = 1'b1;
        state_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FREE_UPD1: begin
        cmd.free_upd1 = 1'b1;
        state_nxt     = sts.both ? ST_FREE_UPD2 : ST_IDLE;
      end
      ST_FREE_UPD2: begin
        cmd.free_upd2 = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/lba_dp.sv */
// Datapath for the largest-block allocator: free-block and grant memories,
// table scan, request counter and output register.
// Depends on lba_pkg.
`timescale 1ns / 1ps

module lba_dp #(
  parameter int MEM_CELLS       = 65536,
  parameter int MAX_REQUESTS    = 4096,
  parameter int MAX_FREE_BLOCKS = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lba_pkg::lba_in_t        in_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output lba_pkg::lba_out_t       out_word,
  input  logic                    cfg_we,
  input  logic [lba_pkg::CELL_W-1:0] cfg_data,
  input  lba_pkg::lba_cmd_t       cmd,
  output lba_pkg::lba_sts_t       sts
);
  import lba_pkg::*;

  localparam int FIW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int HW  = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int RCW = $clog2(MAX_REQUESTS + 1);
  localparam int RST_TOTAL = (MEM_CELLS < 65536) ? MEM_CELLS : 65536;

  // Storage.
  lba_blk_t   fmem [MAX_FREE_BLOCKS];
  lba_grant_t gmem [MAX_REQUESTS + 1];

  logic [RCW-1:0]  req_cnt_r;
  logic [HW-1:0]   hwm_r;
  logic            op_free_r;
  cell_t           want_r;
  logic [TGT_W-1:0] target_r;
  logic [RCW-1:0]  num_r;
  lba_grant_t      g_rd_r;

  logic [HW-1:0]   s_addr_r;
  logic            rd_pend_r;
  lba_blk_t        fb_rd_r;
  logic [FIW-1:0]  rd_idx_r;

  logic            best_found_r;
  logic [FIW-1:0]  best_idx_r;
  cell_t           best_start_r;
  cell_t           best_size_r;
  logic            left_found_r;
  logic [FIW-1:0]  left_idx_r;
  cell_t           left_start_r;
  cell_t           left_size_r;
  logic            right_found_r;
  logic [FIW-1:0]  right_idx_r;
  cell_t           right_size_r;
  logic            emp_found_r;
  logic [FIW-1:0]  emp_idx_r;

  lba_out_t        res_r;
  lba_out_t        out_word_r;
  logic            out_valid_r;

  cell_t           cfg_sat;
  logic [RCW-1:0]  num_new;
  logic            full;
  logic            alloc_fail;
  logic [SUM_W-1:0] pos_end;
  logic [SUM_W-1:0] blk_end;
  logic            slot_ok;
  logic [FIW-1:0]  slot_idx;
  logic            free_apply;
  logic            fw_en;
  logic [FIW-1:0]  fw_addr;
  lba_blk_t        fw_data;
  logic            gw_en;
  logic [RCW-1:0]  gw_addr;
  lba_grant_t      gw_data;

  // Saturated configuration value.
  always_comb begin
    cfg_sat = cfg_data;
    if (32'(cfg_data) > 32'(MEM_CELLS)) begin
      cfg_sat = CELL_W'(MEM_CELLS);
    end
  end

  assign num_new    = req_cnt_r + RCW'(1);
  assign full       = (32'(req_cnt_r) >= 32'(MAX_REQUESTS));
  assign alloc_fail = (want_r == '0) || !best_found_r || (best_size_r < want_r);
  assign pos_end    = SUM_W'(g_rd_r.start) + SUM_W'(g_rd_r.size);
  assign blk_end    = SUM_W'(fb_rd_r.start) + SUM_W'(fb_rd_r.size);
  assign slot_ok    = emp_found_r || (32'(hwm_r) < 32'(MAX_FREE_BLOCKS));
  assign slot_idx   = emp_found_r ? emp_idx_r : hwm_r[FIW-1:0];
  assign free_apply = left_found_r || right_found_r || slot_ok;

  // Status to the controller.
  always_comb begin
    sts           = '0;
    sts.full      = full;
    sts.new_free  = in_word.action;
    sts.op_free   = op_free_r;
    sts.target_ok = (target_r != '0) && (32'(target_r) < 32'(num_r)) &&
                    (32'(target_r) <= 32'(MAX_REQUESTS)) && g_rd_r.granted;
    sts.scan_done = (s_addr_r == hwm_r) && !rd_pend_r;
    sts.both      = left_found_r && right_found_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Free-block memory write port.
  always_comb begin
    fw_en   = 1'b0;
    fw_addr = '0;
    fw_data = '0;
    priority if (!rst_n || cfg_we) begin
      fw_en         = 1'b1;
      fw_data.valid = !rst_n || (cfg_sat != '0);
      fw_data.start = CELL_W'(1);
      fw_data.size  = !rst_n ? CELL_W'(RST_TOTAL) : cfg_sat;
    end else if (cmd.alloc_upd) begin
      fw_en   = !alloc_fail;
      fw_addr = best_idx_r;
      if (best_size_r == want_r) begin
        fw_data = '0;
      end else begin
        fw_data.valid = 1'b1;
        fw_data.start = best_start_r + want_r;
        fw_data.size  = best_size_r - want_r;
      end
    end else if (cmd.free_upd1) begin
      fw_en         = free_apply;
      fw_data.valid = 1'b1;
      priority if (left_found_r) begin
        fw_addr       = left_idx_r;
        fw_data.start = left_start_r;
        fw_data.size  = left_size_r + g_rd_r.size + (right_found_r ? right_size_r : '0);
      end else if (right_found_r) begin
        fw_addr       = right_idx_r;
        fw_data.start = g_rd_r.start;
        fw_data.size  = right_size_r + g_rd_r.size;
      end else begin
        fw_addr       = slot_idx;
        fw_data.start = g_rd_r.start;
        fw_data.size  = g_rd_r.size;
      end
    end else if (cmd.free_upd2) begin
      fw_en   = 1'b1;
      fw_addr = right_idx_r;
      fw_data = '0;
    end
  end

  // Grant memory write port: every numbered request writes its own entry.
  always_comb begin
    gw_en   = 1'b0;
    gw_addr = num_r;
    gw_data = '0;
    priority if (cmd.latch) begin
      gw_en   = !full && (in_word.action == ACT_FREE);
      gw_addr = num_new;
    end else if (cmd.alloc_upd) begin
      gw_en           = 1'b1;
      gw_data.granted = !alloc_fail;
      gw_data.start   = best_start_r;
      gw_data.size    = want_r;
    end else if (cmd.free_upd1) begin
      gw_en   = free_apply;
      gw_addr = RCW'(target_r);
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (fw_en) begin
      fmem[fw_addr] <= fw_data;
    end
    if (gw_en) begin
      gmem[gw_addr] <= gw_data;
    end
    if (cmd.latch) begin
      g_rd_r <= gmem[RCW'(in_word.target_request)];
    end
    if (cmd.scan_step && (s_addr_r < hwm_r)) begin
      fb_rd_r <= fmem[s_addr_r[FIW-1:0]];
    end
  end

  // Control registers: counters, scan state and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cnt_r   <= '0;
      hwm_r       <= HW'(1);
      s_addr_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        req_cnt_r <= '0;
        hwm_r     <= (cfg_sat != '0) ? HW'(1) : '0;
      end else if (cmd.latch && !full) begin
        req_cnt_r <= num_new;
      end else if (cmd.free_upd1 && !left_found_r && !right_found_r &&
                   slot_ok && !emp_found_r) begin
        hwm_r <= hwm_r + HW'(1);
      end
      if (cmd.latch || cfg_we) begin
        s_addr_r  <= '0;
        rd_pend_r <= 1'b0;
      end else if (cmd.scan_step && (s_addr_r < hwm_r)) begin
        s_addr_r  <= s_addr_r + HW'(1);
        rd_pend_r <= 1'b1;
      end else begin
        rd_pend_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request latch and scan trackers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_free_r     <= in_word.action;
      want_r        <= in_word.alloc_size;
      target_r      <= in_word.target_request;
      num_r         <= num_new;
      best_found_r  <= 1'b0;
      left_found_r  <= 1'b0;
      right_found_r <= 1'b0;
      emp_found_r   <= 1'b0;
    end else if (rd_pend_r) begin
      if (!op_free_r) begin
        if (fb_rd_r.valid && (!best_found_r || (fb_rd_r.size > best_size_r) ||
            ((fb_rd_r.size == best_size_r) && (fb_rd_r.start < best_start_r)))) begin
          best_found_r <= 1'b1;
          best_idx_r   <= rd_idx_r;
          best_start_r <= fb_rd_r.start;
          best_size_r  <= fb_rd_r.size;
        end
      end else if (!fb_rd_r.valid) begin
        if (!emp_found_r) begin
          emp_found_r <= 1'b1;
          emp_idx_r   <= rd_idx_r;
        end
      end else begin
        if (SUM_W'(fb_rd_r.start) == pos_end) begin
          right_found_r <= 1'b1;
          right_idx_r   <= rd_idx_r;
          right_size_r  <= fb_rd_r.size;
        end
        if (blk_end == SUM_W'(g_rd_r.start)) begin
          left_found_r <= 1'b1;
          left_idx_r   <= rd_idx_r;
          left_start_r <= fb_rd_r.start;
          left_size_r  <= fb_rd_r.size;
        end
      end
    end
    if (cmd.scan_step && (s_addr_r < hwm_r)) begin
      rd_idx_r <= s_addr_r[FIW-1:0];
    end
    if (cmd.alloc_upd) begin
      res_r.request_number <= REQ_W'(num_r);
      res_r.start_address  <= alloc_fail ? '0 : best_start_r;
      res_r.failed         <= alloc_fail;
    end
    if (cmd.emit) begin
      out_word_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // The scan never runs past the slots in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_addr_r <= hwm_r) else $error("scan address beyond high-water mark");
  // The high-water mark stays within the table.
  a_hwm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hwm_r) <= 32'(MAX_FREE_BLOCKS)) else $error("free table overrun");
  // A word is emitted only into a free output register.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall)) else $error("output word overwritten");
`endif

endmodule

/* src/largest_block_allocator_coalescing.sv */
// Largest-block (worst-fit) allocator with coalescing of freed blocks.
// Sequence: an allocate scans the free table and then answers; a free checks its target,
//   scans and merges (a second update when it merges both sides), or ends at a bad target.
//   The scan reads the free-table slots in use, one per cycle.
// Throughput: one word at a time; a waiting answer keeps the input stalled.
// Reset (synchronous, rst_n low) and a total_cells write restore one free block (none for a zero write).
`timescale 1ns / 1ps

module largest_block_allocator_coalescing #(
  parameter int MEM_CELLS       = 65536,
  parameter int MAX_REQUESTS    = 4096,
  parameter int MAX_FREE_BLOCKS = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lba_pkg::lba_in_t           in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lba_pkg::lba_out_t          out_word,
  input  logic                       cfg_we,
  input  logic [lba_pkg::CELL_W-1:0] cfg_data
);
  import lba_pkg::*;

  lba_cmd_t cmd;
  lba_sts_t sts;

  // Sequencer.
  lba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, scan and output register.
  lba_dp #(
    .MEM_CELLS       (MEM_CELLS),
    .MAX_REQUESTS    (MAX_REQUESTS),
    .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* verif/largest_block_allocator_coalescing_tb.sv */
// Testbench for the largest-block allocator: a queue-fed driver, a monitor and a
// behavioral predictor of worst-fit allocation with coalescing of freed blocks.
// Depends on lba_pkg and largest_block_allocator_coalescing.
`timescale 1ns / 1ps

module largest_block_allocator_coalescing_tb;
  import lba_pkg::*;

  localparam int MEM_CELLS    = 65536;
  localparam int MAX_REQUESTS = 4096;
  localparam int MAX_SLOTS    = 4096;
  localparam int SETTLE       = 64;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lba_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lba_out_t out_word;
  logic     cfg_we = 1'b0;
  cell_t    cfg_data = '0;

  largest_block_allocator_coalescing dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: free-block slots, grants per request, request count.
  lba_blk_t   blocks [MAX_SLOTS];
  lba_grant_t grants [MAX_REQUESTS+1];
  int         req_count;
  int         cells_now;

  lba_in_t  pending_words [$];
  lba_out_t expected_answers [$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;

  function automatic void init_store(int cells);
    foreach (blocks[i]) blocks[i] = '0;
    foreach (grants[i]) grants[i] = '0;
    req_count = 0;
    cells_now = (cells > MEM_CELLS) ? MEM_CELLS : cells;
    if (cells_now > 0) begin
      blocks[0].valid = 1'b1;
      blocks[0].start = 1;
      blocks[0].size = cells_now;
    end
  endfunction

  // Allocate: pick the largest free block, lowest start on ties.
  function automatic void predict_alloc(int num, int want);
    int best;
    lba_out_t ans;
    best = -1;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (!blocks[i].valid) continue;
      if (best < 0 || blocks[i].size > blocks[best].size ||
          (blocks[i].size == blocks[best].size && blocks[i].start < blocks[best].start))
        best = i;
    end
    ans.request_number = num[REQ_W-1:0];
    if (want == 0 || best < 0 || int'(blocks[best].size) < want) begin
      ans.start_address = '0;
      ans.failed = 1'b1;
    end else begin
      grants[num].granted = 1'b1;
      grants[num].start = blocks[best].start;
      grants[num].size = want;
      ans.start_address = blocks[best].start;
      ans.failed = 1'b0;
      if (int'(blocks[best].size) == want) blocks[best].valid = 1'b0;
      else begin
        blocks[best].start = blocks[best].start + want;
        blocks[best].size = blocks[best].size - want;
      end
    end
    expected_answers.push_back(ans);
  endfunction

  // Free: return the cells and merge with touching neighbors.
  function automatic void predict_free(int target);
    int left, right, hole, pos, k;
    left = -1; right = -1; hole = -1;
    if (target == 0 || target > req_count || target > MAX_REQUESTS) return;
    if (!grants[target].granted) return;
    pos = grants[target].start;
    k = grants[target].size;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (!blocks[i].valid) begin
        if (hole < 0) hole = i;
        continue;
      end
      if (int'(blocks[i].start) == pos + k) right = i;
      if (int'(blocks[i].start) + int'(blocks[i].size) == pos) left = i;
    end
    if (left >= 0 && right >= 0) begin
      blocks[left].size = blocks[left].size + k + blocks[right].size;
      blocks[right].valid = 1'b0;
    end else if (left >= 0) begin
      blocks[left].size = blocks[left].size + k;
    end else if (right >= 0) begin
      blocks[right].start = pos;
      blocks[right].size = blocks[right].size + k;
    end else begin
      if (hole < 0) return;
      blocks[hole].valid = 1'b1;
      blocks[hole].start = pos;
      blocks[hole].size = k;
    end
    grants[target].granted = 1'b0;
  endfunction

  function automatic void predict_request(lba_in_t w);
    if (req_count >= MAX_REQUESTS) return;
    req_count++;
    if (w.action == ACT_ALLOC) predict_alloc(req_count, int'(w.alloc_size));
    else predict_free(int'(w.target_request));
  endfunction

  // Driver: present the next pending word, hold it while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_request(in_word);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted answer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected answer %p", out_word);
        end else begin
          lba_out_t exp_w;
          exp_w = expected_answers.pop_front();
          if (exp_w !== out_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected req %0d start %0d failed %0b, got %0d %0d %0b",
                       exp_w.request_number, exp_w.start_address, exp_w.failed,
                       out_word.request_number, out_word.start_address, out_word.failed);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cells(int value);
    @(posedge clk);
    cfg_data <= value[CELL_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    init_store(value & 32'h1FFFF);
  endtask

  function automatic void queue_alloc(int want);
    lba_in_t w;
    w.action = ACT_ALLOC;
    w.alloc_size = want[CELL_W-1:0];
    w.target_request = TGT_W'($urandom);
    pending_words.push_back(w);
  endfunction

  function automatic void queue_free(int target);
    lba_in_t w;
    w.action = ACT_FREE;
    w.alloc_size = CELL_W'($urandom);
    w.target_request = target[TGT_W-1:0];
    pending_words.push_back(w);
  endfunction

  // Mostly allocations of modest size and frees of earlier requests.
  task automatic random_phase(int count, int cells);
    for (int n = 0; n < count; n++) begin
      int base;
      base = req_count + pending_words.size();
      if ($urandom_range(99) < 55)
        queue_alloc($urandom_range(99) < 8 ? $urandom_range(131071)
                                            : $urandom_range(cells / 4 + 1));
      else if ($urandom_range(99) < 85 && base > 0)
        queue_free($urandom_range(base, 1));
      else
        queue_free($urandom_range(8191));
    end
  endtask

  initial begin
    init_store(MEM_CELLS);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, zero size, merges on both sides, bad targets.
    queue_alloc(0);
    queue_alloc(65537);
    queue_alloc(100);
    queue_alloc(200);
    queue_alloc(300);
    queue_free(4);
    queue_free(4);
    queue_free(1);
    queue_free(2);
    queue_free(0);
    queue_free(8191);
    queue_free(5);
    queue_alloc(65536);
    queue_alloc(1);
    queue_alloc(131071);
    queue_free(13);
    queue_alloc(65536);
    wait_drained();

    write_cells(0);
    queue_alloc(1);
    queue_free(1);
    queue_alloc(1);
    wait_drained();

    write_cells(1);
    queue_alloc(1);
    queue_alloc(1);
    queue_free(1);
    queue_alloc(1);
    wait_drained();

    write_cells(131071);
    random_phase(23, 65536);
    wait_drained();

    send_idle_pct = 73;
    write_cells(1000);
    random_phase(23, 1000);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 73;
    write_cells(65536);
    random_phase(23, 65536);
    wait_drained();

    send_idle_pct = 18;
    stall_pct = 18;
    write_cells(37);
    random_phase(23, 37);
    wait_drained();

    if (mismatches == 0 && expected_answers.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
